/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/hdws_pkg.sv */
// ---------------------------------------------------------------------------
// Heading to wheel speeds package
// Shared constants, types and the turning mode update of the controller.
// ---------------------------------------------------------------------------
package hdws_pkg;

  // Default values of the top level parameters.
  localparam int VECTOR_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Turning modes.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SOFT = 2'd1;
  localparam logic [1:0] MODE_HARD = 2'd2;

  // Configuration register indexes.
  localparam int         CFG_IDX_W = 3;
  localparam logic [2:0] CFG_HARD  = 3'd0;
  localparam logic [2:0] CFG_SOFT  = 3'd1;
  localparam logic [2:0] CFG_NONE  = 3'd2;
  localparam logic [2:0] CFG_MAX   = 3'd3;

  // Register values after reset.
  localparam logic [15:0] HARD_RST = 16'd16384;
  localparam logic [15:0] SOFT_RST = 16'd12743;
  localparam logic [15:0] NONE_RST = 16'd1820;
  localparam logic [14:0] MAX_RST  = 15'd2560;

  // Inverse CORDIC gain in Q0.30.
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  // Arctangent of 2^-i, full circle = 2^32.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Turning thresholds and speed limit.
  typedef struct packed {
    logic [15:0] hard;
    logic [15:0] soft_thr;
    logic [15:0] no_turn;
    logic [14:0] speed_lim;
  } turn_cfg_t;

  // Angle and rounded length from the vectoring unit.
  typedef struct packed {
    logic [15:0] angle;
    logic [16:0] length;
  } vec_res_t;

  // Work handed to the wheel speed unit.
  typedef struct packed {
    logic [1:0]  mode;
    logic        angle_pos;
    logic [15:0] mag;
    logic [16:0] length;
  } speed_req_t;

  // Hysteresis update of the turning mode, checks applied in cascade.
  function automatic logic [1:0] next_mode(input logic [1:0] mode,
                                           input logic [15:0] mag,
                                           input turn_cfg_t cfg);
    logic [1:0] m;
    m = mode;
    if (m == MODE_HARD && mag <= cfg.soft_thr) begin
      m = MODE_SOFT;
    end
    if (m == MODE_SOFT) begin
      if (mag > cfg.hard) begin
        m = MODE_HARD;
      end else if (mag <= cfg.no_turn) begin
        m = MODE_NONE;
      end
    end
    if (m == MODE_NONE) begin
      if (mag > cfg.hard) begin
        m = MODE_HARD;
      end else if (mag > cfg.no_turn) begin
        m = MODE_SOFT;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/hdws_cordic.sv */
// ---------------------------------------------------------------------------
// Vectoring CORDIC
// Iterative angle and length of a heading vector, one rotation per cycle.
// ---------------------------------------------------------------------------
module hdws_cordic #(
  parameter int VECTOR_WIDTH = hdws_pkg::VECTOR_WIDTH_DEF,
  parameter int CORDIC_STEPS = hdws_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] heading_x,
  input  logic signed [15:0] heading_y,
  output logic               done,
  output hdws_pkg::vec_res_t res
);

  localparam int DW = VECTOR_WIDTH + 19;
  localparam int SW = $clog2(CORDIC_STEPS);
  localparam logic [DW-1:0] HALF = DW'(1) << (VECTOR_WIDTH - 1);

  logic signed [DW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [31:0]          acc_r, acc_nxt;
  logic [SW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;

  logic signed [16:0]   hx_e, hy_e, px, py;
  logic [31:0]          pacc;
  logic signed [DW-1:0] dx, dy;
  logic [31:0]          step_ang;
  logic [DW-1:0]        x_pos, x_half;
  logic [31:0]          acc_round;

  // Quadrant pre-rotation by +-90 degrees so that x starts non-negative.
  always_comb begin
    hx_e = {heading_x[15], heading_x};
    hy_e = {heading_y[15], heading_y};
    px   = hx_e;
    py   = hy_e;
    pacc = 32'h0000_0000;
    if (hx_e[16]) begin
      if (!hy_e[16]) begin
        px   = hy_e;
        py   = -hx_e;
        pacc = 32'h4000_0000;
      end else begin
        px   = -hy_e;
        py   = hx_e;
        pacc = 32'hC000_0000;
      end
    end
  end

  // One rotation step with floor shifts of the previous x and y.
  assign dx       = y_r >>> cnt_r;
  assign dy       = x_r >>> cnt_r;
  assign step_ang = hdws_pkg::ATAN_TAB[5'(cnt_r)];

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = $signed({{(DW-17){px[16]}}, px}) <<< VECTOR_WIDTH;
      y_nxt    = $signed({{(DW-17){py[16]}}, py}) <<< VECTOR_WIDTH;
      acc_nxt  = pacc;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[DW-1]) begin
        x_nxt   = x_r + dx;
        y_nxt   = y_r - dy;
        acc_nxt = acc_r + step_ang;
      end else begin
        x_nxt   = x_r - dx;
        y_nxt   = y_r + dy;
        acc_nxt = acc_r - step_ang;
      end
      if (cnt_r == SW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  // Angle rounded half up to 16 bits; length rounded half up to an unsigned Q17.0 integer.
  assign acc_round  = acc_r + 32'h0000_8000;
  assign x_pos      = x_r[DW-1] ? '0 : x_r;
  assign x_half     = x_pos + HALF;
  assign res.angle  = acc_round[31:16];
  assign res.length = x_half[VECTOR_WIDTH+16:VECTOR_WIDTH];
  assign done       = done_r;

endmodule

/* rtl/hdws_speed.sv */
// ---------------------------------------------------------------------------
// Wheel speed unit
// Bit-serial gain correction, soft turn factor and wheel speed assignment.
// ---------------------------------------------------------------------------
module hdws_speed (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  hdws_pkg::speed_req_t   req,
  input  hdws_pkg::turn_cfg_t    cfg,
  output logic                   done,
  output logic signed [16:0]     left_speed,
  output logic signed [16:0]     right_speed
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_BASE = 3'd2;
  localparam logic [2:0] PH_MUL  = 3'd3;
  localparam logic [2:0] PH_DIV  = 3'd4;
  localparam logic [2:0] PH_FIN  = 3'd5;

  localparam int LEN_BITS = 17;
  localparam int MUL_BITS = 16;
  localparam int DIV_BITS = 16;

  logic [2:0]           ph_r, ph_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  hdws_pkg::speed_req_t req_r, req_nxt;
  logic [16:0]          sh_r, sh_nxt;
  logic [47:0]          acc_r, acc_nxt;
  logic [14:0]          base_r, base_nxt;
  logic [16:0]          rem_r, rem_nxt;
  logic [15:0]          q_r, q_nxt;
  logic signed [16:0]   left_r, left_nxt, right_r, right_nxt;

  logic [47:0] len_sum;
  logic [17:0] len;
  logic [16:0] d;
  logic [32:0] num;
  logic [17:0] trial, divisor;
  logic signed [16:0] s1, s2;

  assign len_sum = acc_r + 48'(32'h2000_0000);
  assign len     = len_sum[47:30];
  assign d       = {1'b0, cfg.hard} - {1'b0, req_r.mag};
  assign trial   = {rem_r, sh_r[16]};
  assign divisor = {1'b0, cfg.hard, 1'b0};

  // Speed pair for the final mode; s1 goes to the inner wheel of a turn.
  always_comb begin
    case (req_r.mode)
      hdws_pkg::MODE_SOFT: begin
        if (cfg.hard == 16'd0) begin
          s1 = {2'b00, base_r};
        end else if (d[16]) begin
          s1 = '0;
        end else begin
          s1 = {1'b0, q_r};
        end
        s2 = $signed({1'b0, base_r, 1'b0}) - s1;
      end
      hdws_pkg::MODE_HARD: begin
        s1 = -$signed({2'b00, cfg.speed_lim});
        s2 = $signed({2'b00, cfg.speed_lim});
      end
      default: begin
        s1 = {2'b00, base_r};
        s2 = {2'b00, base_r};
      end
    endcase
  end

  // Sequencer over the serial phases.
  always_comb begin
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    req_nxt   = req_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    num       = '0;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          req_nxt = req;
          sh_nxt  = req.length;
          acc_nxt = '0;
          cnt_nxt = '0;
          ph_nxt  = PH_LEN;
        end
      end
      // Length times inverse gain, one length bit per cycle, MSB first.
      PH_LEN: begin
        acc_nxt = {acc_r[46:0], 1'b0} + (sh_r[16] ? 48'(hdws_pkg::INV_GAIN_Q30) : 48'd0);
        sh_nxt  = {sh_r[15:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(LEN_BITS - 1)) begin
          ph_nxt = PH_BASE;
        end
      end
      // Round the length and clamp it to the maximum speed.
      PH_BASE: begin
        base_nxt = (len < {3'b000, cfg.speed_lim}) ? len[14:0] : cfg.speed_lim;
        sh_nxt   = {d[15:0], 1'b0};
        acc_nxt  = '0;
        cnt_nxt  = '0;
        ph_nxt   = (req_r.mode == hdws_pkg::MODE_SOFT) ? PH_MUL : PH_FIN;
      end
      // Base times angle margin, one margin bit per cycle.
      PH_MUL: begin
        acc_nxt = {acc_r[46:0], 1'b0} + (sh_r[16] ? 48'(base_r) : 48'd0);
        sh_nxt  = {sh_r[15:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(MUL_BITS - 1)) begin
          num     = {acc_nxt[31:0], 1'b0} + 33'(cfg.hard);
          rem_nxt = num[32:16];
          sh_nxt  = {num[15:0], 1'b0};
          q_nxt   = '0;
          cnt_nxt = '0;
          ph_nxt  = PH_DIV;
        end
      end
      // Restoring division by twice the hard threshold, one quotient bit a cycle.
      PH_DIV: begin
        if (trial >= divisor) begin
          rem_nxt = 17'(trial - divisor);
          q_nxt   = {q_r[14:0], 1'b1};
        end else begin
          rem_nxt = trial[16:0];
          q_nxt   = {q_r[14:0], 1'b0};
        end
        sh_nxt  = {sh_r[15:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_BITS - 1)) begin
          ph_nxt = PH_FIN;
        end
      end
      // A positive angle turns left, so the left wheel is the inner one.
      PH_FIN: begin
        left_nxt  = req_r.angle_pos ? s1 : s2;
        right_nxt = req_r.angle_pos ? s2 : s1;
        done_nxt  = 1'b1;
        ph_nxt    = PH_IDLE;
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    sh_r    <= sh_nxt;
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign done        = done_r;
  assign left_speed  = left_r;
  assign right_speed = right_r;

endmodule

/* rtl/heading_to_differential_wheel_speeds.sv */
// ---------------------------------------------------------------------------
// Heading to differential wheel speeds
// Turning controller with hysteresis for a two-wheeled drive.
// ---------------------------------------------------------------------------
// One item is worked on at a time. A zero heading goes straight to the
// output register. Any other heading runs through the iterative CORDIC, a
// handoff, the bit-serial gain multiplier and the steps that clamp, pick
// the wheels and load the output register. In a soft turn the serial
// multiplier and the serial divider come between the clamp and the wheel
// pick. A result that still waits in the output register delays the load
// by as long as it waits. The next item is accepted as soon as the result
// has moved to the output register, even while that result still waits to
// be taken.
`include "assert_macros.svh"

module heading_to_differential_wheel_speeds #(
  parameter int VECTOR_WIDTH = hdws_pkg::VECTOR_WIDTH_DEF,
  parameter int CORDIC_STEPS = hdws_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [hdws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata,
  // Heading items.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_heading_x,
  input  logic signed [15:0]            in_heading_y,
  // Wheel speed items.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [16:0]            out_left_speed,
  output logic signed [16:0]            out_right_speed,
  output logic [1:0]                    out_turn_mode_out
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CORDIC = 2'd1;
  localparam logic [1:0] ST_SPEED  = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic                  zero_r;
  hdws_pkg::turn_cfg_t   cfg_r;
  logic                  out_valid_r;
  logic signed [16:0]    out_left_r, out_right_r;
  logic [1:0]            out_mode_r;

  logic                  in_accept, is_zero, out_load;
  logic                  cordic_start, cordic_done;
  hdws_pkg::vec_res_t    vec_res;
  logic [15:0]           mag;
  logic                  angle_pos;
  logic [1:0]            mode_new;
  logic                  spd_start, spd_done;
  hdws_pkg::speed_req_t  spd_req;
  logic signed [16:0]    spd_left, spd_right;
  logic                  out_hard, out_none;
  logic [16:0]           speed_sum;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hard      <= hdws_pkg::HARD_RST;
      cfg_r.soft_thr  <= hdws_pkg::SOFT_RST;
      cfg_r.no_turn   <= hdws_pkg::NONE_RST;
      cfg_r.speed_lim <= hdws_pkg::MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hdws_pkg::CFG_HARD: cfg_r.hard      <= cfg_wdata;
        hdws_pkg::CFG_SOFT: cfg_r.soft_thr  <= cfg_wdata;
        hdws_pkg::CFG_NONE: cfg_r.no_turn   <= cfg_wdata;
        hdws_pkg::CFG_MAX:  cfg_r.speed_lim <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Handshake terms.
  assign in_ready     = (state_r == ST_IDLE);
  assign in_accept    = in_valid && in_ready;
  assign is_zero      = (in_heading_x == 16'sd0) && (in_heading_y == 16'sd0);
  assign out_load     = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign cordic_start = in_accept && !is_zero;

  hdws_cordic #(
    .VECTOR_WIDTH (VECTOR_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cordic_start),
    .heading_x (in_heading_x),
    .heading_y (in_heading_y),
    .done      (cordic_done),
    .res       (vec_res)
  );

  // Angle magnitude, turn direction and the new turning mode.
  assign mag       = vec_res.angle[15] ? (~vec_res.angle + 16'd1) : vec_res.angle;
  assign angle_pos = !vec_res.angle[15] && (vec_res.angle != 16'd0);
  assign mode_new  = hdws_pkg::next_mode(mode_r, mag, cfg_r);

  assign spd_req.mode      = mode_new;
  assign spd_req.angle_pos = angle_pos;
  assign spd_req.mag       = mag;
  assign spd_req.length    = vec_res.length;
  assign spd_start         = (state_r == ST_CORDIC) && cordic_done;

  hdws_speed u_speed (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (spd_start),
    .req         (spd_req),
    .cfg         (cfg_r),
    .done        (spd_done),
    .left_speed  (spd_left),
    .right_speed (spd_right)
  );

  // Item sequencer.
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = is_zero ? ST_OUT : ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          mode_nxt  = mode_new;
          state_nxt = ST_SPEED;
        end
      end
      ST_SPEED: begin
        if (spd_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= hdws_pkg::MODE_NONE;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      if (in_accept) begin
        zero_r <= is_zero;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register; a zero heading gives zero speeds and keeps the mode.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= zero_r ? 17'sd0 : spd_left;
      out_right_r <= zero_r ? 17'sd0 : spd_right;
      out_mode_r  <= mode_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_speed    = out_left_r;
  assign out_right_speed   = out_right_r;
  assign out_turn_mode_out = out_mode_r;

  // Terms for the speed shape checks of the offered result.
  assign out_hard  = out_valid && (out_turn_mode_out == hdws_pkg::MODE_HARD);
  assign out_none  = out_valid && (out_turn_mode_out == hdws_pkg::MODE_NONE);
  assign speed_sum = 17'(out_left_speed + out_right_speed);

  // Unit completions line up with the sequencer, and the hard and no-turn modes give their speed shapes.
  `ASSERT_NEVER(a_cordic_done_in_state, clk, rst_n, cordic_done && (state_r != ST_CORDIC))
  `ASSERT_NEVER(a_speed_done_in_state, clk, rst_n, spd_done && (state_r != ST_SPEED))
  `ASSERT_IMPLY(a_hard_opposite, clk, rst_n, out_hard, speed_sum == 17'd0)
  `ASSERT_IMPLY(a_none_equal, clk, rst_n, out_none, out_left_speed == out_right_speed)

endmodule

/* tb/wheel_speed_checker.sv */
// ---------------------------------------------------------------------------
// Wheel speed checker
// Watches the configuration port and both item channels of the heading to
// wheel speed controller, predicts each result and compares it field by field.
// ---------------------------------------------------------------------------
module wheel_speed_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hdws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [15:0]             in_heading_x,
  input  logic signed [15:0]             in_heading_y,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [16:0]             out_left_speed,
  input  logic signed [16:0]             out_right_speed,
  input  logic [1:0]                     out_turn_mode_out,
  output int                             failures,
  output int                             pending
);
  import hdws_pkg::*;

  localparam int ROT_STEPS = CORDIC_STEPS_DEF;
  localparam int FRAC_BITS = VECTOR_WIDTH_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic [1:0]         mode;
  } wheel_speeds_t;

  // Shadow copy of the registers and the turning state.
  logic [15:0] hard_thr;
  logic [15:0] soft_thr;
  logic [15:0] straight_thr;
  logic [14:0] speed_cap;
  logic [1:0]  turn_state;

  wheel_speeds_t expected_speeds[$];
  wheel_speeds_t predicted;
  wheel_speeds_t oldest;

  // Works out the wheel speeds and the new mode for one heading.
  function automatic wheel_speeds_t predict_wheel_speeds(input logic signed [15:0] hx,
                                                         input logic signed [15:0] hy);
    wheel_speeds_t res;
    longint vx, vy, tmp, dx, dy, xr, len, base, s1, s2, h, d;
    logic [31:0] acc;
    logic [31:0] rounded;
    logic signed [15:0] ang;
    int mag;
    logic [1:0] m;
    res.mode = turn_state;
    res.left = '0;
    res.right = '0;
    if (hx == 0 && hy == 0) begin
      return res;
    end
    vx = longint'(hx) * (longint'(1) <<< FRAC_BITS);
    vy = longint'(hy) * (longint'(1) <<< FRAC_BITS);
    acc = 32'h0000_0000;
    // Rotate by a quarter turn so that x is not negative.
    if (vx < 0) begin
      if (vy >= 0) begin
        tmp = vx;
        vx = vy;
        vy = -tmp;
        acc = 32'h4000_0000;
      end else begin
        tmp = vx;
        vx = -vy;
        vy = tmp;
        acc = 32'hC000_0000;
      end
    end
    // Vectoring iterations drive y toward zero.
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx = vx + dx;
        vy = vy - dy;
        acc = acc + ATAN_TAB[i];
      end else begin
        vx = vx - dx;
        vy = vy + dy;
        acc = acc - ATAN_TAB[i];
      end
    end
    rounded = acc + 32'h0000_8000;
    ang = rounded[31:16];
    mag = (ang < 0) ? -int'(ang) : int'(ang);

    // Length with the gain taken out, clamped to the speed cap.
    if (vx < 0) begin
      vx = 0;
    end
    xr = (vx + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    len = (xr * longint'(INV_GAIN_Q30) + (longint'(1) <<< 29)) >>> 30;
    base = (len < longint'(speed_cap)) ? len : longint'(speed_cap);

    // Hysteresis on the angle magnitude, one check after the other.
    m = turn_state;
    if (m == MODE_HARD && mag <= int'(soft_thr)) begin
      m = MODE_SOFT;
    end
    if (m == MODE_SOFT) begin
      if (mag > int'(hard_thr)) begin
        m = MODE_HARD;
      end else if (mag <= int'(straight_thr)) begin
        m = MODE_NONE;
      end
    end
    if (m == MODE_NONE) begin
      if (mag > int'(hard_thr)) begin
        m = MODE_HARD;
      end else if (mag > int'(straight_thr)) begin
        m = MODE_SOFT;
      end
    end

    // Speeds of the inner and outer wheel.
    if (m == MODE_SOFT) begin
      h = longint'(hard_thr);
      d = h - longint'(mag);
      if (h == 0 || d < 0) begin
        s1 = (h == 0) ? base : 0;
      end else begin
        s1 = (2 * base * d + h) / (2 * h);
      end
      s2 = 2 * base - s1;
    end else if (m == MODE_HARD) begin
      s1 = -longint'(speed_cap);
      s2 = longint'(speed_cap);
    end else begin
      s1 = base;
      s2 = base;
    end

    if (ang > 0) begin
      res.left = s1[16:0];
      res.right = s2[16:0];
    end else begin
      res.left = s2[16:0];
      res.right = s1[16:0];
    end
    res.mode = m;
    return res;
  endfunction

  // Track registers, predict accepted items and compare accepted results.
  always @(posedge clk) begin
    if (!rst_n) begin
      hard_thr <= HARD_RST;
      soft_thr <= SOFT_RST;
      straight_thr <= NONE_RST;
      speed_cap <= MAX_RST;
      turn_state <= MODE_NONE;
      expected_speeds.delete();
      failures <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HARD: begin
            hard_thr <= cfg_wdata;
          end
          CFG_SOFT: begin
            soft_thr <= cfg_wdata;
          end
          CFG_NONE: begin
            straight_thr <= cfg_wdata;
          end
          CFG_MAX: begin
            speed_cap <= cfg_wdata[14:0];
          end
          default: begin
          end
        endcase
      end

      // The result is taken off before a new item is predicted.
      if (out_valid && out_ready) begin
        if (expected_speeds.size() == 0) begin
          if (failures < REPORT_LIMIT) begin
            $display("ERROR: unexpected result left=%0d right=%0d mode=%0d",
                     out_left_speed, out_right_speed, out_turn_mode_out);
          end
          failures <= failures + 1;
        end else begin
          oldest = expected_speeds.pop_front();
          if (out_left_speed !== oldest.left || out_right_speed !== oldest.right ||
              out_turn_mode_out !== oldest.mode) begin
            if (failures < REPORT_LIMIT) begin
              $display("ERROR: expected left=%0d right=%0d mode=%0d, got left=%0d right=%0d mode=%0d",
                       $signed(oldest.left), $signed(oldest.right), oldest.mode,
                       out_left_speed, out_right_speed, out_turn_mode_out);
            end
            failures <= failures + 1;
          end
        end
      end

      if (in_valid && in_ready) begin
        predicted = predict_wheel_speeds(in_heading_x, in_heading_y);
        expected_speeds.insert(expected_speeds.size(), predicted);
        turn_state <= predicted.mode;
      end
      pending <= expected_speeds.size();
    end
  end

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// Heading to wheel speeds testbench
// Drives headings through several threshold and speed settings, with random
// gaps on both channels, and leaves checking to the wheel speed checker.
// ---------------------------------------------------------------------------
module testbench;
  import hdws_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;
  // A register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]           cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [15:0]    in_heading_x;
  logic signed [15:0]    in_heading_y;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [16:0]    out_left_speed;
  logic signed [16:0]    out_right_speed;
  logic [1:0]            out_turn_mode_out;

  int failures;
  int pending;
  int idle_cycles;
  logic no_idle;
  int walk_x;
  int walk_y;

  heading_to_differential_wheel_speeds dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_heading_x(in_heading_x),
    .in_heading_y(in_heading_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_left_speed(out_left_speed),
    .out_right_speed(out_right_speed),
    .out_turn_mode_out(out_turn_mode_out)
  );

  wheel_speed_checker u_speed_check (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_heading_x(in_heading_x),
    .in_heading_y(in_heading_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_left_speed(out_left_speed),
    .out_right_speed(out_right_speed),
    .out_turn_mode_out(out_turn_mode_out),
    .failures(failures),
    .pending(pending)
  );

  // Clock with a period of 10.
  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls now and then unless idling is switched off.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 15);
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offers one heading item and returns at the edge that accepts it.
  task automatic send_heading(input logic signed [15:0] hx, input logic signed [15:0] hy);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 15) begin
      gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_heading_x <= hx;
    in_heading_y <= hy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender back until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_turning(input logic [15:0] hard, input logic [15:0] fallback,
                             input logic [15:0] straight, input logic [15:0] cap);
    drain_results();
    write_reg(CFG_HARD, hard);
    write_reg(CFG_SOFT, fallback);
    write_reg(CFG_NONE, straight);
    write_reg(CFG_MAX, cap);
  endtask

  function automatic int clamp16(input int v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Random headings: mostly a slowly sweeping heading that walks the modes,
  // plus raw words, tiny vectors and zero vectors.
  task automatic run_random(input int count);
    int pick;
    int hx;
    int hy;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        hx = 0;
        hy = 0;
      end else if (pick < 33) begin
        hx = int'($signed(16'($urandom)));
        hy = int'($signed(16'($urandom)));
      end else if (pick < 43) begin
        hx = $urandom_range(0, 16) - 8;
        hy = $urandom_range(0, 16) - 8;
      end else begin
        if ($urandom_range(9) == 0) begin
          walk_x = int'($signed(16'($urandom)));
        end
        walk_y = clamp16(walk_y + $urandom_range(0, 4095) - 2048);
        hx = walk_x;
        hy = walk_y;
      end
      send_heading(hx[15:0], hy[15:0]);
      if (i == count / 2) begin
        drain_results();
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_heading_x = '0;
    in_heading_y = '0;
    out_ready = 1'b0;
    no_idle = 1'b0;
    walk_x = 1024;
    walk_y = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed headings at the reset settings: extremes of both fields,
    // the angle of exactly pi, zero vectors in each mode and a walk
    // through the hysteresis.
    send_heading(16'sd0, 16'sd0);
    send_heading(16'sd32767, 16'sd0);
    send_heading(-16'sd32768, 16'sd0);
    send_heading(16'sd0, 16'sd32767);
    send_heading(16'sd0, -16'sd32768);
    send_heading(16'sd32767, 16'sd32767);
    send_heading(-16'sd32768, -16'sd32768);
    send_heading(-16'sd32768, 16'sd32767);
    send_heading(16'sd32767, -16'sd32768);
    send_heading(16'sd1, 16'sd0);
    send_heading(-16'sd1, 16'sd0);
    send_heading(16'sd0, 16'sd1);
    send_heading(16'sd0, -16'sd1);
    send_heading(-16'sd1, -16'sd1);
    send_heading(16'sd256, 16'sd40);
    send_heading(16'sd256, 16'sd80);
    send_heading(16'sd256, 16'sd200);
    send_heading(16'sd0, 16'sd0);
    send_heading(-16'sd256, 16'sd10);
    send_heading(16'sd256, 16'sd230);
    send_heading(-16'sd256, -16'sd10);
    send_heading(16'sd0, 16'sd0);
    send_heading(16'sd256, 16'sd0);

    // Reset values written back, then the widest and narrowest settings.
    set_turning(HARD_RST, SOFT_RST, NONE_RST, 16'(MAX_RST));
    run_random(400);
    set_turning(16'd32768, 16'd32768, 16'd32768, 16'd32767);
    run_random(150);
    set_turning(16'd1, 16'd0, 16'd0, 16'd0);
    run_random(150);

    // Random settings in range, one phase without any idling.
    for (int p = 0; p < 4; p++) begin
      int hard;
      int fallback;
      hard = $urandom_range(1, 32768);
      fallback = $urandom_range(0, hard);
      set_turning(hard[15:0], fallback[15:0], 16'($urandom_range(0, fallback)),
                  16'($urandom_range(0, 32767)));
      no_idle <= (p == 2);
      run_random(200);
      no_idle <= 1'b0;
    end

    // Thresholds beyond their range, a cap with its top bit set and a
    // write to an index the block ignores.
    set_turning(16'd65535, 16'd50000, 16'd40000, 16'hFFFF);
    write_reg(CFG_SPARE, 16'h5A5A);
    run_random(150);

    // Zero hard threshold.
    set_turning(16'd0, 16'd0, 16'd0, 16'd1000);
    run_random(100);

    // Wait for the last results and let the block settle.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
